// ===== hdl/cscan_pkg.sv =====
package cscan_pkg;

   // Field widths of the request, result and register ports.
   localparam int POS_W     = 16;
   localparam int CYL_W     = 17;
   localparam int SEEK_W    = 22;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_DOWN = 2'd2;

   // Reset value of the cylinder count register.
   localparam logic [CYL_W-1:0] CYL_COUNT_RESET = 17'h10000;

   // Phases of the service order.
   localparam int PH_W = 2;
   localparam logic [PH_W-1:0] PH_G1   = 2'd0;
   localparam logic [PH_W-1:0] PH_BND1 = 2'd1;
   localparam logic [PH_W-1:0] PH_BND2 = 2'd2;
   localparam logic [PH_W-1:0] PH_G2   = 2'd3;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [SEEK_W-1:0] seek_type;

endpackage

// ===== hdl/cscan_ram.sv =====
module cscan_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cscan_disk_scheduler.sv =====
// C-SCAN disk scheduler. Request cylinders arrive one item at a time and are kept in
// ascending order in a RAM with one write and one read port; each item is inserted by
// walking down from the top of the store, moving every stored entry larger than it up
// one place, until a compare finds an entry that is not larger or the walk reaches the
// bottom of the store; a request that finds the store full is dropped. req_ready stays
// low meanwhile. On an item marked last, the block then scans the store for the first
// entry at or above head_start and sets up the walk. It then emits the C-SCAN order:
// each stored request is read from the RAM, its distance and the running sum are
// formed, and the result is offered until rsp_ready takes it; the wrap offers its two
// boundary visits in turn unless it is skipped, and the walk then turns to the second
// group. One result is in flight at a time, and a single subtract-and-add unit serves
// every visit. Registers on the csr port are to be written by the user only while the
// block is idle; the block itself does not enforce this. The batch is cleared once the
// result flagged last_visit is taken; requests beyond MAX_REQUESTS in a batch are dropped.
module cscan_disk_scheduler #(
   parameter int MAX_REQUESTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cscan_pkg::POS_W-1:0]       req_request_cylinder,
   input  logic                              req_is_last,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cscan_pkg::POS_W-1:0]       rsp_visit_position,
   output logic                              rsp_is_boundary,
   output logic [cscan_pkg::SEEK_W-1:0]      rsp_seek_so_far,
   output logic                              rsp_last_visit,
   // Configuration port
   input  logic                              csr_write_en,
   input  logic [cscan_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cscan_pkg::CYL_W-1:0]       csr_data
);

   localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // Sequencer states.
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] S_INS_CHK = 4'd1;
   localparam logic [ST_W-1:0] S_INS_CMP = 4'd2;
   localparam logic [ST_W-1:0] S_SPL_CHK = 4'd3;
   localparam logic [ST_W-1:0] S_SPL_CMP = 4'd4;
   localparam logic [ST_W-1:0] S_START   = 4'd5;
   localparam logic [ST_W-1:0] S_G_RD    = 4'd6;
   localparam logic [ST_W-1:0] S_G_EMIT  = 4'd7;
   localparam logic [ST_W-1:0] S_WAIT    = 4'd8;
   localparam logic [ST_W-1:0] S_WRAP    = 4'd9;
   localparam logic [ST_W-1:0] S_G2      = 4'd10;

   logic [ST_W-1:0]             state_ff;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               pos_ff;
   logic [CW-1:0]               split_ff;
   logic [CW-1:0]               idx_ff;
   logic [CW-1:0]               rem_ff;
   logic [CW-1:0]               g2n_ff;
   logic [cscan_pkg::PH_W-1:0]  phase_ff;
   cscan_pkg::pos_type          value_ff;
   logic                        last_ff;
   cscan_pkg::pos_type          head_ff;
   cscan_pkg::seek_type         seek_ff;

   cscan_pkg::pos_type          head_start_ff;
   logic [cscan_pkg::CYL_W-1:0] cyl_count_ff;
   logic                        sweep_down_ff;

   logic                        rsp_valid_ff;
   cscan_pkg::pos_type          rsp_pos_ff;
   logic                        rsp_bnd_ff;
   cscan_pkg::seek_type         rsp_seek_ff;
   logic                        rsp_last_ff;

   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   cscan_pkg::pos_type          ram_wr_data;
   logic [AW-1:0]               ram_rd_addr;
   cscan_pkg::pos_type          ram_rd_data;

   logic [cscan_pkg::CYL_W-1:0] cyl_m1;
   cscan_pkg::pos_type          end_cyl;
   cscan_pkg::pos_type          target1;
   cscan_pkg::pos_type          target2;
   cscan_pkg::pos_type          emit_pos;
   cscan_pkg::pos_type          emit_dist;
   cscan_pkg::seek_type         emit_seek;
   logic [CW-1:0]               g1n;
   logic [CW-1:0]               idx_step;
   logic [CW-1:0]               pos_m1;
   logic                        rsp_take;

   cscan_ram #(
      .WIDTH (cscan_pkg::POS_W),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The end cylinder is the count minus one, clamped to 1..65535.
   always_comb begin
      cyl_m1 = cyl_count_ff - cscan_pkg::CYL_W'(1);
      if (cyl_count_ff < cscan_pkg::CYL_W'(2)) begin
         end_cyl = cscan_pkg::POS_W'(1);
      end else if (cyl_m1[cscan_pkg::CYL_W-1]) begin
         end_cyl = '1;
      end else begin
         end_cyl = cyl_m1[cscan_pkg::POS_W-1:0];
      end
      target1 = sweep_down_ff ? '0 : end_cyl;
      target2 = sweep_down_ff ? end_cyl : '0;
   end

   // Shared distance unit: the position of the visit being emitted, its distance
   // from the head and the new running seek.
   always_comb begin
      if (state_ff == S_G_EMIT) begin
         emit_pos = ram_rd_data;
      end else if (state_ff == S_WRAP) begin
         emit_pos = target1;
      end else begin
         emit_pos = target2;
      end
      emit_dist = (emit_pos >= head_ff) ? (emit_pos - head_ff) : (head_ff - emit_pos);
      emit_seek = seek_ff + cscan_pkg::SEEK_W'(emit_dist);
   end

   // Size of the first group and the walking direction.
   assign g1n      = sweep_down_ff ? split_ff : (count_ff - split_ff);
   assign idx_step = sweep_down_ff ? (idx_ff - CNT_ONE) : (idx_ff + CNT_ONE);
   assign pos_m1   = pos_ff - CNT_ONE;
   assign rsp_take = rsp_valid_ff && rsp_ready;

   // RAM port control.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff[AW-1:0];
      ram_wr_data = value_ff;
      ram_rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_INS_CHK: begin
            ram_rd_addr = pos_m1[AW-1:0];
            ram_wr_en   = (count_ff < MAX_CNT) && (pos_ff == '0);
         end
         S_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data > value_ff) begin
               ram_wr_data = ram_rd_data;
            end
         end
         S_SPL_CHK: begin
            ram_rd_addr = split_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_start_ff <= '0;
         cyl_count_ff  <= cscan_pkg::CYL_COUNT_RESET;
         sweep_down_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cscan_pkg::CSR_HEAD_START: head_start_ff <= csr_data[cscan_pkg::POS_W-1:0];
            cscan_pkg::CSR_CYL_COUNT:  cyl_count_ff  <= csr_data;
            cscan_pkg::CSR_SWEEP_DOWN: sweep_down_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         value_ff <= req_request_cylinder;
         last_ff  <= req_is_last;
      end
   end

   // Sequencer: sorted insertion, split search and the C-SCAN walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         split_ff     <= '0;
         idx_ff       <= '0;
         rem_ff       <= '0;
         g2n_ff       <= '0;
         phase_ff     <= cscan_pkg::PH_G1;
         head_ff      <= '0;
         seek_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_pos_ff   <= '0;
         rsp_bnd_ff   <= 1'b0;
         rsp_seek_ff  <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  pos_ff   <= count_ff;
                  split_ff <= '0;
                  state_ff <= S_INS_CHK;
               end
            end
            S_INS_CHK: begin
               if (count_ff >= MAX_CNT) begin
                  state_ff <= last_ff ? S_SPL_CHK : S_IDLE;
               end else if (pos_ff == '0) begin
                  count_ff <= count_ff + CNT_ONE;
                  state_ff <= last_ff ? S_SPL_CHK : S_IDLE;
               end else begin
                  state_ff <= S_INS_CMP;
               end
            end
            S_INS_CMP: begin
               if (ram_rd_data > value_ff) begin
                  pos_ff   <= pos_m1;
                  state_ff <= S_INS_CHK;
               end else begin
                  count_ff <= count_ff + CNT_ONE;
                  state_ff <= last_ff ? S_SPL_CHK : S_IDLE;
               end
            end
            S_SPL_CHK: begin
               state_ff <= (split_ff == count_ff) ? S_START : S_SPL_CMP;
            end
            S_SPL_CMP: begin
               if (ram_rd_data < head_start_ff) begin
                  split_ff <= split_ff + CNT_ONE;
                  state_ff <= S_SPL_CHK;
               end else begin
                  state_ff <= S_START;
               end
            end
            S_START: begin
               head_ff  <= head_start_ff;
               seek_ff  <= '0;
               phase_ff <= cscan_pkg::PH_G1;
               rem_ff   <= g1n;
               idx_ff   <= sweep_down_ff ? (split_ff - CNT_ONE) : split_ff;
               g2n_ff   <= sweep_down_ff ? (count_ff - split_ff) : split_ff;
               state_ff <= (g1n == '0) ? S_WRAP : S_G_RD;
            end
            S_G_RD: begin
               state_ff <= S_G_EMIT;
            end
            S_G_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_pos_ff   <= emit_pos;
               rsp_bnd_ff   <= 1'b0;
               rsp_seek_ff  <= emit_seek;
               if (phase_ff == cscan_pkg::PH_G2) begin
                  rsp_last_ff <= (rem_ff == CNT_ONE);
               end else begin
                  rsp_last_ff <= (rem_ff == CNT_ONE) && (g2n_ff == '0) &&
                                 (emit_pos == target1);
               end
               head_ff  <= emit_pos;
               seek_ff  <= emit_seek;
               rem_ff   <= rem_ff - CNT_ONE;
               idx_ff   <= idx_step;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (rsp_take) begin
                  if (rsp_last_ff) begin
                     rsp_valid_ff <= 1'b0;
                     count_ff     <= '0;
                     state_ff     <= S_IDLE;
                  end else begin
                     unique case (phase_ff)
                        cscan_pkg::PH_G1: begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= (rem_ff == '0) ? S_WRAP : S_G_RD;
                        end
                        cscan_pkg::PH_BND1: begin
                           // Second half of the wrap: jump to the far end.
                           rsp_valid_ff <= 1'b1;
                           rsp_pos_ff   <= emit_pos;
                           rsp_bnd_ff   <= 1'b1;
                           rsp_seek_ff  <= emit_seek;
                           rsp_last_ff  <= (g2n_ff == '0);
                           head_ff      <= emit_pos;
                           seek_ff      <= emit_seek;
                           phase_ff     <= cscan_pkg::PH_BND2;
                        end
                        cscan_pkg::PH_BND2: begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_G2;
                        end
                        default: begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_G_RD;
                        end
                     endcase
                  end
               end
            end
            S_WRAP: begin
               // Visit the end of the sweep unless the head already sits there.
               if (head_ff != target1) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_ff   <= emit_pos;
                  rsp_bnd_ff   <= 1'b1;
                  rsp_seek_ff  <= emit_seek;
                  rsp_last_ff  <= 1'b0;
                  head_ff      <= emit_pos;
                  seek_ff      <= emit_seek;
                  phase_ff     <= cscan_pkg::PH_BND1;
                  state_ff     <= S_WAIT;
               end else begin
                  state_ff <= S_G2;
               end
            end
            S_G2: begin
               phase_ff <= cscan_pkg::PH_G2;
               rem_ff   <= g2n_ff;
               idx_ff   <= sweep_down_ff ? (count_ff - CNT_ONE) : '0;
               state_ff <= S_G_RD;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visit_position = rsp_pos_ff;
   assign rsp_is_boundary    = rsp_bnd_ff;
   assign rsp_seek_so_far    = rsp_seek_ff;
   assign rsp_last_visit     = rsp_last_ff;

   // A result is never pending while new requests are taken.
   a_no_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("result pending while accepting requests");

   // The store never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("request count exceeds store depth");

   // Taking the final result empties the batch and reopens the request channel.
   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (count_ff == '0) && req_ready)
      else $error("batch not cleared after final result");

   // The running seek only grows within a batch.
   a_seek_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_ff) |=> seek_ff >= $past(seek_ff))
      else $error("running seek decreased within a batch");

   // Boundary visits are only emitted during the wrap phases.
   a_bnd_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bnd_ff) |->
         (phase_ff == cscan_pkg::PH_BND1 || phase_ff == cscan_pkg::PH_BND2))
      else $error("boundary visit outside the wrap");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int MAX_REQ        = 32;
   localparam int DRAIN_CYCLES   = 4 * MAX_REQ + 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRESSURE_HOLD  = 300;
   localparam int RANDOM_ITEMS   = 360;
   localparam int PHASE_ITEMS    = 60;

   typedef struct {
      cscan_pkg::pos_type cyl;
      logic               last;
   } request_item_type;

   typedef struct {
      cscan_pkg::pos_type  pos;
      logic                boundary;
      cscan_pkg::seek_type seek;
      logic                last;
   } visit_type;

   // Block ports; every input starts at a known value.
   logic                            clock                = 1'b0;
   logic                            reset                = 1'b1;
   logic                            req_valid            = 1'b0;
   logic                            req_ready;
   cscan_pkg::pos_type              req_request_cylinder = '0;
   logic                            req_is_last          = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready            = 1'b0;
   cscan_pkg::pos_type              rsp_visit_position;
   logic                            rsp_is_boundary;
   cscan_pkg::seek_type             rsp_seek_so_far;
   logic                            rsp_last_visit;
   logic                            csr_write_en         = 1'b0;
   logic [cscan_pkg::CSR_IDX_W-1:0] csr_index            = cscan_pkg::CSR_HEAD_START;
   logic [cscan_pkg::CYL_W-1:0]     csr_data             = '0;

   // Shadow copy of the registers and of the scheduler state.
   cscan_pkg::pos_type          cfg_head    = '0;
   logic [cscan_pkg::CYL_W-1:0] cfg_cyl     = cscan_pkg::CYL_COUNT_RESET;
   logic                        cfg_down    = 1'b0;
   cscan_pkg::pos_type          sorted_cyl[MAX_REQ];
   int                          sorted_count = 0;
   cscan_pkg::pos_type          track_head  = '0;
   cscan_pkg::seek_type         track_seek  = '0;

   request_item_type queued_requests[$];
   visit_type        pending_visits[$];

   int   fail_count     = 0;
   logic req_took       = 1'b0;
   logic no_idle        = 1'b0;
   logic pressure_armed = 1'b0;
   int   gap_left       = 0;
   int   stall_left     = 0;

   cscan_disk_scheduler #(
      .MAX_REQUESTS(MAX_REQ)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_request_cylinder (req_request_cylinder),
      .req_is_last          (req_is_last),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_visit_position   (rsp_visit_position),
      .rsp_is_boundary      (rsp_is_boundary),
      .rsp_seek_so_far      (rsp_seek_so_far),
      .rsp_last_visit       (rsp_last_visit),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   // The end cylinder is the count minus one, clamped to 1..65535.
   function automatic cscan_pkg::pos_type end_cylinder();
      if (cfg_cyl < 2)
         return 16'd1;
      if (cfg_cyl > 17'h10000)
         return 16'hFFFF;
      return cscan_pkg::pos_type'(cfg_cyl - 17'd1);
   endfunction

   // Move the head to a position and record the visit with its running seek.
   function automatic void add_visit(cscan_pkg::pos_type pos, logic boundary);
      cscan_pkg::seek_type distance;
      visit_type           v;
      distance = (pos > track_head) ? cscan_pkg::seek_type'(pos - track_head)
                                    : cscan_pkg::seek_type'(track_head - pos);
      track_seek = track_seek + distance;
      track_head = pos;
      v.pos      = pos;
      v.boundary = boundary;
      v.seek     = track_seek;
      v.last     = 1'b0;
      pending_visits.push_back(v);
   endfunction

   // Insert one request into the sorted store; on the last item of a batch,
   // work out the whole C-SCAN service order and clear the batch.
   function automatic void schedule_request(request_item_type it);
      int                 idx;
      int                 split;
      int                 j;
      cscan_pkg::pos_type end_cyl;
      if (sorted_count < MAX_REQ) begin
         idx = sorted_count;
         while (idx > 0 && sorted_cyl[idx-1] > it.cyl) begin
            sorted_cyl[idx] = sorted_cyl[idx-1];
            idx--;
         end
         sorted_cyl[idx] = it.cyl;
         sorted_count++;
      end
      if (!it.last)
         return;

      end_cyl    = end_cylinder();
      track_head = cfg_head;
      track_seek = '0;
      split      = 0;
      while (split < sorted_count && sorted_cyl[split] < cfg_head)
         split++;

      if (!cfg_down) begin
         for (j = split; j < sorted_count; j++)
            add_visit(sorted_cyl[j], 1'b0);
         // The wrap is skipped when the head already sits on the end cylinder.
         if (track_head != end_cyl) begin
            add_visit(end_cyl, 1'b1);
            add_visit('0, 1'b1);
         end
         for (j = 0; j < split; j++)
            add_visit(sorted_cyl[j], 1'b0);
      end else begin
         for (j = split; j > 0; j--)
            add_visit(sorted_cyl[j-1], 1'b0);
         if (track_head != '0) begin
            add_visit('0, 1'b1);
            add_visit(end_cyl, 1'b1);
         end
         for (j = sorted_count; j > split; j--)
            add_visit(sorted_cyl[j-1], 1'b0);
      end
      pending_visits[pending_visits.size()-1].last = 1'b1;
      sorted_count = 0;
   endfunction

   // Idle stretches: mostly short, a few long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 92)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Request values lean on the edges: zero, all ones, the end cylinder and the head.
   function automatic cscan_pkg::pos_type pick_cylinder();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return end_cylinder();
         3:       return cfg_head;
         4:       return cfg_head - 16'd1;
         5, 6, 7: return cscan_pkg::pos_type'($urandom_range(0, end_cylinder()));
         default: return cscan_pkg::pos_type'($urandom());
      endcase
   endfunction

   task automatic queue_item(cscan_pkg::pos_type cyl, logic last);
      request_item_type it;
      it.cyl  = cyl;
      it.last = last;
      queued_requests.push_back(it);
   endtask

   task automatic write_csr(logic [cscan_pkg::CSR_IDX_W-1:0] idx,
                            logic [cscan_pkg::CYL_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      case (idx)
         cscan_pkg::CSR_HEAD_START: cfg_head = data[cscan_pkg::POS_W-1:0];
         cscan_pkg::CSR_CYL_COUNT:  cfg_cyl  = data;
         cscan_pkg::CSR_SWEEP_DOWN: cfg_down = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_settings(cscan_pkg::pos_type head,
                                 logic [cscan_pkg::CYL_W-1:0] cyl, logic down);
      write_csr(cscan_pkg::CSR_CYL_COUNT, cyl);
      write_csr(cscan_pkg::CSR_HEAD_START, {1'b0, head});
      write_csr(cscan_pkg::CSR_SWEEP_DOWN, {{(cscan_pkg::CYL_W-1){1'b0}}, down});
   endtask

   // Wait until every item is taken and every visit has come, then let the
   // block settle before touching its registers.
   task automatic wait_idle();
      while (queued_requests.size() != 0 || req_valid || pending_visits.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Request driver: one item at a time, with random gaps between items.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (queued_requests.size() != 0) begin
            request_item_type it;
            it = queued_requests.pop_front();
            req_valid            <= 1'b1;
            req_request_cylinder <= it.cyl;
            req_is_last          <= it.last;
            gap_left = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, and once a long hold-off while the
   // sender keeps offering items so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (pressure_armed && rsp_valid) begin
         pressure_armed = 1'b0;
         stall_left     = PRESSURE_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = idle_length() - 1;
         rsp_ready <= 1'b0;
      end
   end

   // Monitor: predict on each accepted item, then check each accepted result.
   always @(posedge clock) begin : monitor
      request_item_type it;
      visit_type        want;
      req_took = (req_valid && req_ready === 1'b1);
      if (req_took) begin
         it.cyl  = req_request_cylinder;
         it.last = req_is_last;
         schedule_request(it);
      end
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_visits.size() == 0) begin
            $error("unexpected result: visit_position %0d", rsp_visit_position);
            fail_count++;
         end else begin
            want = pending_visits.pop_front();
            if (rsp_visit_position !== want.pos) begin
               $error("visit_position: expected %0d, actual %0d", want.pos, rsp_visit_position);
               fail_count++;
            end
            if (rsp_is_boundary !== want.boundary) begin
               $error("is_boundary: expected %0d, actual %0d", want.boundary, rsp_is_boundary);
               fail_count++;
            end
            if (rsp_seek_so_far !== want.seek) begin
               $error("seek_so_far: expected %0d, actual %0d", want.seek, rsp_seek_so_far);
               fail_count++;
            end
            if (rsp_last_visit !== want.last) begin
               $error("last_visit: expected %0d, actual %0d", want.last, rsp_last_visit);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Stimulus: directed batches first, then random batches under random settings.
   initial begin : stimulus
      int                          total;
      int                          phase;
      int                          phase_items;
      int                          size;
      int                          k;
      logic [cscan_pkg::CYL_W-1:0] cyl;
      cscan_pkg::pos_type          head;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a lone request at zero, then a mixed batch.
      queue_item(16'd0, 1'b1);
      queue_item(16'hFFFF, 1'b0);
      queue_item(16'h8000, 1'b0);
      queue_item(16'd1, 1'b1);

      // Head on the end cylinder sweeping up: no wrap.
      wait_idle();
      apply_settings(16'hFFFF, 17'h10000, 1'b0);
      queue_item(16'hFFFF, 1'b1);
      queue_item(16'd100, 1'b0);
      queue_item(16'd200, 1'b0);
      queue_item(16'd100, 1'b1);

      // Smallest disk sweeping down from zero, requests beyond the end.
      wait_idle();
      apply_settings(16'd0, 17'd2, 1'b1);
      queue_item(16'd5, 1'b0);
      queue_item(16'd0, 1'b1);

      // Cylinder count of zero acts as two.
      wait_idle();
      apply_settings(16'h8000, 17'd0, 1'b1);
      queue_item(16'h8000, 1'b0);
      queue_item(16'h7FFF, 1'b0);
      queue_item(16'hFFFF, 1'b1);

      // Count above the largest disk acts as the largest disk.
      wait_idle();
      apply_settings(16'd1234, 17'h1FFFF, 1'b0);
      queue_item(16'd1234, 1'b0);
      queue_item(16'd1233, 1'b0);
      queue_item(16'd40000, 1'b0);
      queue_item(16'd0, 1'b1);

      // Count of one, head on the end cylinder.
      wait_idle();
      apply_settings(16'd1, 17'd1, 1'b0);
      queue_item(16'd1, 1'b1);
      queue_item(16'd0, 1'b0);
      queue_item(16'd1, 1'b1);

      // Random phases; the first opens with a batch that overfills the store.
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 7))
            0:       cyl = 17'd2;
            1:       cyl = 17'h10000;
            2:       cyl = 17'($urandom_range(0, 1));
            3:       cyl = 17'h1FFFF;
            4, 5:    cyl = 17'($urandom_range(2, 300));
            default: cyl = 17'($urandom_range(2, 65536));
         endcase
         write_csr(cscan_pkg::CSR_CYL_COUNT, cyl);
         case ($urandom_range(0, 5))
            0:       head = '0;
            1:       head = '1;
            2:       head = end_cylinder();
            3:       head = cscan_pkg::pos_type'($urandom());
            default: head = cscan_pkg::pos_type'($urandom_range(0, end_cylinder()));
         endcase
         write_csr(cscan_pkg::CSR_HEAD_START, {1'b0, head});
         write_csr(cscan_pkg::CSR_SWEEP_DOWN, 17'($urandom_range(0, 1)));
         no_idle        = (phase == 2);
         pressure_armed = (phase == 1);

         phase_items = 0;
         while (phase_items < PHASE_ITEMS && total + phase_items < RANDOM_ITEMS) begin
            if ((phase == 0 && phase_items == 0) || $urandom_range(0, 9) == 0)
               size = $urandom_range(MAX_REQ + 1, MAX_REQ + 8);
            else
               size = $urandom_range(1, 8);
            for (k = 1; k <= size; k++)
               queue_item(pick_cylinder(), k == size);
            phase_items += size;
         end
         total += phase_items;
         phase++;
      end

      wait_idle();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
